// ===== design/ppd_pkg.sv =====
// Package for the passive pad type detector.
// Holds the per-port state type, activity mask bits, pad type codes and the
// mask/classify functions. No dependencies.
package ppd_pkg;

    typedef logic [8:0]  t_mask;
    typedef logic [1:0]  t_pad;

    // Per-port detector state
    typedef struct packed {
        t_mask       edge_prev_mask;
        logic        edge_armed;
        t_mask       hold_last_mask;
        logic [31:0] hold_since_ms;
        logic        hold_latched;
    } t_port_state;

    // Activity mask bits
    localparam t_mask M_NEO     = 9'h001;
    localparam t_mask M_LEFT    = 9'h002;
    localparam t_mask M_LEFT_TR = 9'h004;
    localparam t_mask M_FIRE    = 9'h008;
    localparam t_mask M_TR_LOW  = 9'h010;
    localparam t_mask M_DIR_ACT = 9'h020;
    localparam t_mask M_RIGHT   = 9'h040;
    localparam t_mask M_UP      = 9'h080;
    localparam t_mask M_DOWN    = 9'h100;
    localparam t_mask M_SMS_OK  = M_FIRE | M_LEFT | M_LEFT_TR | M_TR_LOW | M_DIR_ACT
                                | M_RIGHT | M_UP | M_DOWN;

    // Pad type codes
    localparam t_pad PAD_NONE   = 2'd0;
    localparam t_pad PAD_NEOGEO = 2'd1;
    localparam t_pad PAD_SMS    = 2'd2;
    localparam t_pad PAD_JPC    = 2'd3;

    localparam logic [15:0] STABLE_TIME_RESET = 16'd1000;

    // Pin levels (low = active, th high = clear) to activity mask
    function automatic t_mask levels_to_mask(input logic [8:0] lv);
        logic  start_lo, up_lo, down_lo, left_lo, right_lo;
        logic  fire_lo, tr_lo, clr_hi, left_tr_lo;
        t_mask m;
        start_lo   = ~lv[0];
        up_lo      = ~lv[1];
        down_lo    = ~lv[2];
        left_lo    = ~lv[3];
        right_lo   = ~lv[4];
        fire_lo    = ~lv[5];
        tr_lo      = ~lv[6];
        clr_hi     = lv[7];
        left_tr_lo = ~lv[8];
        m = '0;
        if (start_lo)   m = m | M_NEO;
        if (left_lo)    m = m | M_LEFT;
        if (left_tr_lo) m = m | M_LEFT_TR;
        if (fire_lo)    m = m | M_FIRE;
        if (tr_lo)      m = m | M_TR_LOW;
        if (right_lo)   m = m | M_RIGHT;
        if (up_lo)      m = m | M_UP;
        if (down_lo)    m = m | M_DOWN;
        if (up_lo || down_lo || left_lo || right_lo) m = m | M_DIR_ACT;
        // all directions low with clear high: idle pattern
        if (clr_hi && up_lo && down_lo && left_lo && right_lo) m = '0;
        return m;
    endfunction

    function automatic logic sms_assist(input t_mask m);
        logic conflict;
        conflict = ((m & M_LEFT) != '0 && (m & M_RIGHT) != '0)
                || ((m & M_UP) != '0 && (m & M_DOWN) != '0);
        return ((m & M_FIRE) != '0) && ((m & ~M_SMS_OK) == '0) && !conflict;
    endfunction

    function automatic t_pad classify(input t_mask m);
        logic left;
        t_pad r;
        left = (m & M_LEFT) != '0;
        if ((m & M_NEO) != '0)                     r = PAD_NEOGEO;
        else if (sms_assist(m))                    r = PAD_SMS;
        else if (left && (m & M_TR_LOW) != '0)     r = PAD_JPC;
        else if (!left && (m & M_LEFT_TR) != '0)   r = PAD_JPC;
        else                                       r = PAD_NONE;
        return r;
    endfunction

endpackage

// ===== design/passive_pad_type_detector_top.sv =====
// Top level of the passive pad type detector: handshakes, config register,
// per-port state registers. Depends on ppd_pkg and ppd_step.
// Each probe beat is taken into an input register; once the result register is
// free, its port's state is read, updated and written back while the pad type
// goes to the result register. One probe is accepted every cycle while the
// result channel does not stall. Every probe gives exactly one result; a port
// at or above PORT_COUNT gives type none and leaves all state alone.
// stable_time_ms resets to 1000; the user must write it through the config
// channel only while idle, and the block itself does not enforce this.
module passive_pad_type_detector_top #(
    parameter int PORT_COUNT = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // probe channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_port,
    input  logic [31:0]         i_now_ms,
    input  logic [8:0]          i_first_levels,
    input  logic [8:0]          i_confirm_levels,
    input  logic [8:0]          i_held_levels,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppd_pkg::t_pad       o_pad_type,
    // config channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_stable_time_ms
);
    import ppd_pkg::*;

    localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    logic                r_in_vld;
    logic [7:0]          r_port;
    logic [31:0]         r_now_ms;
    logic [8:0]          r_first;
    logic [8:0]          r_confirm;
    logic [8:0]          r_held;
    logic                r_out_vld;
    t_pad                r_pad_type;
    logic [15:0]         r_stable_time;
    t_port_state         r_state [PORT_COUNT];

    logic                in_acc;
    logic                adv;
    logic                port_ok;
    logic [PIDX_W-1:0]   pidx;
    t_port_state         cur_state;
    t_port_state         n_state;
    t_pad                step_type;
    t_pad                n_pad_type;

    // Handshake: input register drains whenever the result register is free
    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && r_out_vld && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_pad_type  = r_pad_type;
    assign o_cfg_ready = 1'b1;

    // Port select
    assign port_ok   = r_port < 8'(PORT_COUNT);
    assign pidx      = r_port[PIDX_W-1:0];
    assign cur_state = r_state[pidx];

    ppd_step u_step (
        .i_state          (cur_state),
        .i_now_ms         (r_now_ms),
        .i_first_levels   (r_first),
        .i_confirm_levels (r_confirm),
        .i_held_levels    (r_held),
        .i_stable_time_ms (r_stable_time),
        .o_state          (n_state),
        .o_pad_type       (step_type)
    );

    assign n_pad_type = port_ok ? step_type : PAD_NONE;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
        if (in_acc) begin
            r_port    <= i_port;
            r_now_ms  <= i_now_ms;
            r_first   <= i_first_levels;
            r_confirm <= i_confirm_levels;
            r_held    <= i_held_levels;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (adv) begin
            r_pad_type <= n_pad_type;
        end
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_time <= STABLE_TIME_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stable_time <= i_cfg_stable_time_ms;
        end
    end

    // Per-port state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORT_COUNT; i++) begin
                r_state[i] <= '0;
            end
        end else if (adv && port_ok) begin
            r_state[pidx] <= n_state;
        end
    end

endmodule

// ===== design/ppd_step.sv =====
// One probe step of the pad type detector: edge path then hold path.
// Combinational: takes the port's current state, returns next state and type.
// Depends on ppd_pkg.
module ppd_step (
    input  ppd_pkg::t_port_state i_state,
    input  logic [31:0]          i_now_ms,
    input  logic [8:0]           i_first_levels,
    input  logic [8:0]           i_confirm_levels,
    input  logic [8:0]           i_held_levels,
    input  logic [15:0]          i_stable_time_ms,
    output ppd_pkg::t_port_state o_state,
    output ppd_pkg::t_pad        o_pad_type
);
    import ppd_pkg::*;

    t_mask       m_first;
    t_mask       m_conf;
    t_mask       m_held;
    t_mask       m_rise;
    t_pad        edge_type;
    t_pad        hold_type;
    t_pad        prev_type;
    logic [31:0] elapsed;
    logic        time_ok;

    assign m_first   = levels_to_mask(i_first_levels);
    assign m_conf    = levels_to_mask(i_confirm_levels);
    assign m_held    = levels_to_mask(i_held_levels);
    assign m_rise    = m_conf & ~i_state.edge_prev_mask;
    assign hold_type = classify(m_held);
    assign prev_type = classify(i_state.hold_last_mask);
    // elapsed time wraps modulo 2^32
    assign elapsed   = i_now_ms - i_state.hold_since_ms;
    assign time_ok   = elapsed >= {16'd0, i_stable_time_ms};

    always_comb begin
        o_state    = i_state;
        edge_type  = PAD_NONE;
        o_pad_type = PAD_NONE;

        // Edge path: arm on idle mask, confirm a new rising bit
        if (m_first == '0) begin
            o_state.edge_prev_mask = '0;
            o_state.edge_armed     = 1'b1;
        end else if (!i_state.edge_armed || (m_first & ~i_state.edge_prev_mask) == '0) begin
            o_state.edge_prev_mask = m_first;
        end else if (m_conf != m_first) begin
            o_state.edge_prev_mask = m_conf;
        end else begin
            o_state.edge_prev_mask = m_conf;
            o_state.edge_armed     = 1'b0;
            if (m_rise != '0) begin
                edge_type = classify(m_rise);
                if (edge_type == PAD_SMS && !sms_assist(m_conf)) edge_type = PAD_NONE;
            end
        end

        // Hold path only when the edge path gave nothing
        if (edge_type != PAD_NONE) begin
            o_pad_type = edge_type;
        end else if (hold_type == PAD_NONE) begin
            // release: report a stable, unreported mask
            if (!i_state.hold_latched && i_state.hold_last_mask != '0 &&
                prev_type != PAD_NONE && i_state.hold_since_ms != '0 && time_ok) begin
                o_pad_type = prev_type;
            end
            o_state.hold_last_mask = m_held;
            o_state.hold_since_ms  = '0;
            o_state.hold_latched   = 1'b0;
        end else if (i_state.hold_latched) begin
            o_pad_type = PAD_NONE;
        end else if (m_held != i_state.hold_last_mask) begin
            o_state.hold_last_mask = m_held;
            o_state.hold_since_ms  = i_now_ms;
        end else if (i_state.hold_since_ms == '0) begin
            o_state.hold_since_ms  = i_now_ms;
        end else if (time_ok) begin
            o_state.hold_latched   = 1'b1;
            o_pad_type             = hold_type;
        end
    end

endmodule

// ===== test/tb_passive_pad_type_detector_top.sv =====
// Testbench for passive_pad_type_detector_top: directed and random probes with idling
// on both channels, checked against a predictor of the per-port edge and hold state.
// Depends on ppd_pkg and the detector RTL.
module tb_passive_pad_type_detector_top;
    import ppd_pkg::*;

    localparam int PORT_COUNT  = 2;
    localparam int STUCK_LIMIT = 4000;

    // pin positions in a levels snapshot
    localparam int PIN_START   = 0;
    localparam int PIN_UP      = 1;
    localparam int PIN_DOWN    = 2;
    localparam int PIN_LEFT    = 3;
    localparam int PIN_RIGHT   = 4;
    localparam int PIN_FIRE    = 5;
    localparam int PIN_TR      = 6;
    localparam int PIN_TH      = 7;
    localparam int PIN_LEFT_TR = 8;

    // fixed snapshots for the directed part
    localparam logic [8:0] PINS_IDLE   = 9'h181;  // th high, all directions low
    localparam logic [8:0] PINS_ALL_HI = 9'h1FF;
    localparam logic [8:0] PINS_ALL_LO = 9'h000;
    localparam logic [8:0] PINS_NEO    = 9'h1FE;  // start low
    localparam logic [8:0] PINS_SMS    = 9'h1D7;  // fire and left low
    localparam logic [8:0] PINS_JPC_A  = 9'h1B7;  // left and tr low
    localparam logic [8:0] PINS_JPC_B  = 9'h0FF;  // left low only while tr driven
    localparam logic [8:0] PINS_UP     = 9'h1FD;  // up low: active but no type

    typedef struct {
        logic [7:0]  port;
        logic [31:0] now;
        logic [8:0]  first;
        logic [8:0]  confirm;
        logic [8:0]  held;
    } probe_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_port = '0;
    logic [31:0] i_now_ms = '0;
    logic [8:0]  i_first_levels = '0;
    logic [8:0]  i_confirm_levels = '0;
    logic [8:0]  i_held_levels = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_pad        o_pad_type;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_stable_time_ms = '0;

    // stimulus and expectations
    probe_t      probe_q [$];
    t_pad        pad_expect_q [$];
    logic [31:0] clock_ms [PORT_COUNT];

    // predicted detector state
    logic [15:0] stable_ms = STABLE_TIME_RESET;
    t_mask       arm_prev [PORT_COUNT];
    logic        armed [PORT_COUNT];
    t_mask       held_mask [PORT_COUNT];
    logic [31:0] held_since [PORT_COUNT];
    logic        held_reported [PORT_COUNT];

    // handshake bookkeeping
    probe_t      tx_next;
    probe_t      mon_probe;
    t_pad        exp_pad;
    logic        probe_taken = 1'b0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    logic        rx_hold_req = 1'b0;
    int          tx_gap = 0;
    int          tx_roll = 0;
    int          rx_hold_left = 0;
    int          rx_roll = 0;
    int          stuck_cycles = 0;
    int          fails = 0;

    passive_pad_type_detector_top #(
        .PORT_COUNT(PORT_COUNT)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_port               (i_port),
        .i_now_ms             (i_now_ms),
        .i_first_levels       (i_first_levels),
        .i_confirm_levels     (i_confirm_levels),
        .i_held_levels        (i_held_levels),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_pad_type           (o_pad_type),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_stable_time_ms (i_cfg_stable_time_ms)
    );

    always #10 i_clk = ~i_clk;

    // pin levels to activity bits; low means active, th high means clear
    function automatic t_mask pins_to_activity(input logic [8:0] pins);
        t_mask a;
        a = '0;
        // clear high with every direction low reads as nothing attached
        if (pins[PIN_TH] && pins[PIN_RIGHT:PIN_UP] == 4'b0000) return '0;
        if (!pins[PIN_START])   a |= M_NEO;
        if (!pins[PIN_LEFT])    a |= M_LEFT;
        if (!pins[PIN_LEFT_TR]) a |= M_LEFT_TR;
        if (!pins[PIN_FIRE])    a |= M_FIRE;
        if (!pins[PIN_TR])      a |= M_TR_LOW;
        if (!pins[PIN_RIGHT])   a |= M_RIGHT;
        if (!pins[PIN_UP])      a |= M_UP;
        if (!pins[PIN_DOWN])    a |= M_DOWN;
        if (pins[PIN_RIGHT:PIN_UP] != 4'b1111) a |= M_DIR_ACT;
        return a;
    endfunction

    function automatic logic fire_assist_ok(input t_mask a);
        logic opposed;
        opposed = ((a & M_LEFT) != '0 && (a & M_RIGHT) != '0)
               || ((a & M_UP) != '0 && (a & M_DOWN) != '0);
        return (a & M_FIRE) != '0 && (a & ~M_SMS_OK) == '0 && !opposed;
    endfunction

    function automatic t_pad pad_of_activity(input t_mask a);
        if ((a & M_NEO) != '0) return PAD_NEOGEO;
        if (fire_assist_ok(a)) return PAD_SMS;
        if ((a & M_LEFT) != '0 && (a & M_TR_LOW) != '0) return PAD_JPC;
        if ((a & M_LEFT) == '0 && (a & M_LEFT_TR) != '0) return PAD_JPC;
        return PAD_NONE;
    endfunction

    // pad type for one probe; updates the predicted per-port state
    function automatic t_pad predict_pad(input probe_t pr);
        t_mask       m;
        t_mask       c;
        t_mask       hm;
        t_pad        r;
        t_pad        last_pad;
        int          p;
        logic [31:0] elapsed;
        if (pr.port >= PORT_COUNT) return PAD_NONE;
        p = pr.port;
        // edge path: armed by an idle mask, confirmed by the second snapshot
        r = PAD_NONE;
        m = pins_to_activity(pr.first);
        if (m == '0) begin
            arm_prev[p] = '0;
            armed[p] = 1'b1;
        end else if (!armed[p] || (m & ~arm_prev[p]) == '0) begin
            arm_prev[p] = m;
        end else begin
            c = pins_to_activity(pr.confirm);
            if (c != m) begin
                arm_prev[p] = c;
            end else begin
                r = pad_of_activity(c & ~arm_prev[p]);
                if (r == PAD_SMS && !fire_assist_ok(c)) r = PAD_NONE;
                arm_prev[p] = c;
                armed[p] = 1'b0;
            end
        end
        if (r != PAD_NONE) return r;
        // hold path: report once a typed mask stays put long enough
        hm = pins_to_activity(pr.held);
        r = pad_of_activity(hm);
        elapsed = pr.now - held_since[p];
        if (r == PAD_NONE) begin
            // release: report a stable hold that never latched
            last_pad = pad_of_activity(held_mask[p]);
            if (!held_reported[p] && last_pad != PAD_NONE && held_since[p] != '0
                    && elapsed >= stable_ms)
                r = last_pad;
            held_mask[p] = hm;
            held_since[p] = '0;
            held_reported[p] = 1'b0;
            return r;
        end
        if (held_reported[p]) return PAD_NONE;
        if (hm != held_mask[p]) begin
            held_mask[p] = hm;
            held_since[p] = pr.now;
            return PAD_NONE;
        end
        // a start time of zero counts as no start time
        if (held_since[p] == '0) begin
            held_since[p] = pr.now;
            return PAD_NONE;
        end
        if (elapsed < stable_ms) return PAD_NONE;
        held_reported[p] = 1'b1;
        return r;
    endfunction

    function automatic void queue_probe(input logic [7:0] port, input logic [31:0] now,
                                        input logic [8:0] f, input logic [8:0] c,
                                        input logic [8:0] h);
        probe_t pr;
        pr.port = port;
        pr.now = now;
        pr.first = f;
        pr.confirm = c;
        pr.held = h;
        probe_q.push_back(pr);
    endfunction

    // advance a port's time: mostly short steps, some near the stable time, rare jumps
    function automatic logic [31:0] next_probe_time(input int p);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            clock_ms[p] += $urandom_range(0, stable_ms / 6 + 1);
        else if (r < 9)
            clock_ms[p] += $urandom_range(stable_ms / 2, stable_ms + 3);
        else
            clock_ms[p] += $urandom;
        return clock_ms[p];
    endfunction

    function automatic logic [8:0] idle_pins();
        logic [8:0] v;
        v = $urandom_range(0, 511);
        v[PIN_TH] = 1'b1;
        v[PIN_RIGHT:PIN_UP] = 4'b0000;
        return v;
    endfunction

    // directions active but no fire, start or left: classifies as none
    function automatic logic [8:0] none_pins();
        logic [8:0] v;
        v = 9'h1FF;
        v[PIN_UP] = 1'b0;
        v[PIN_RIGHT] = $urandom_range(0, 1);
        v[PIN_DOWN] = $urandom_range(0, 1);
        v[PIN_TH] = $urandom_range(0, 1);
        return v;
    endfunction

    // snapshot biased toward one of the pad types
    function automatic logic [8:0] pad_pins();
        logic [8:0] v;
        v = $urandom_range(0, 511);
        case ($urandom_range(0, 4))
            0: v[PIN_START] = 1'b0;
            1: begin
                v = 9'h1FF;
                v[PIN_FIRE] = 1'b0;
                v[$urandom_range(PIN_UP, PIN_RIGHT)] = 1'b0;
                v[PIN_TH] = $urandom_range(0, 1);
            end
            2: begin
                v[PIN_START] = 1'b1;
                v[PIN_LEFT] = 1'b0;
                v[PIN_TR] = 1'b0;
            end
            3: begin
                v[PIN_START] = 1'b1;
                v[PIN_LEFT] = 1'b1;
                v[PIN_LEFT_TR] = 1'b0;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (probe_q.size() != 0 || i_in_valid || pad_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // probe driver: next beat from the queue after a random gap
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || probe_taken) begin
                probe_taken = 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (probe_q.size() > 0) begin
                    tx_next = probe_q.pop_front();
                    i_port <= tx_next.port;
                    i_now_ms <= tx_next.now;
                    i_first_levels <= tx_next.first;
                    i_confirm_levels <= tx_next.confirm;
                    i_held_levels <= tx_next.held;
                    i_in_valid <= 1'b1;
                    tx_roll = $urandom_range(0, 99);
                    tx_gap = tx_calm ? 0 : (tx_roll < 65) ? 0
                           : (tx_roll < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls, occasional runs, one long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = 150;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_calm) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 3) rx_hold_left = $urandom_range(8, 30);
            i_out_stall <= (rx_roll < 25);
        end
    end

    // monitor: predict on accepted probes, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                mon_probe.port = i_port;
                mon_probe.now = i_now_ms;
                mon_probe.first = i_first_levels;
                mon_probe.confirm = i_confirm_levels;
                mon_probe.held = i_held_levels;
                pad_expect_q.push_back(predict_pad(mon_probe));
                probe_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pad_expect_q.size() == 0) begin
                    $error("unexpected result beat: pad_type %0d", o_pad_type);
                    fails++;
                end else begin
                    exp_pad = pad_expect_q.pop_front();
                    if (o_pad_type !== exp_pad) begin
                        $error("pad_type mismatch: expected %0d, actual %0d", exp_pad, o_pad_type);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) stable_ms = i_cfg_stable_time_ms;
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [15:0] plan [6];
        logic [8:0]  pat;
        logic [8:0]  lv;
        int          ph;
        int          p;
        int          r;
        foreach (clock_ms[k]) begin
            clock_ms[k] = $urandom;
            arm_prev[k] = '0;
            armed[k] = 1'b0;
            held_mask[k] = '0;
            held_since[k] = '0;
            held_reported[k] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each pad type on the edge path, hold latch, release report
        queue_probe(0, 0, PINS_ALL_HI, PINS_ALL_HI, PINS_ALL_HI);
        queue_probe(0, 5, PINS_NEO, PINS_NEO, PINS_NEO);
        queue_probe(0, 6, PINS_NEO, PINS_NEO, PINS_NEO);
        queue_probe(0, 1500, PINS_NEO, PINS_NEO, PINS_NEO);
        queue_probe(0, 1501, PINS_IDLE, PINS_IDLE, PINS_IDLE);
        queue_probe(0, 1502, PINS_SMS, PINS_SMS, PINS_SMS);
        queue_probe(0, 1503, PINS_IDLE, PINS_IDLE, PINS_IDLE);
        queue_probe(0, 1504, PINS_JPC_A, PINS_JPC_A, PINS_JPC_A);
        queue_probe(0, 1505, PINS_IDLE, PINS_IDLE, PINS_IDLE);
        queue_probe(0, 1506, PINS_JPC_B, PINS_JPC_B, PINS_JPC_B);
        queue_probe(0, 1507, PINS_IDLE, PINS_IDLE, PINS_IDLE);
        // confirm snapshot disagrees, then release of an unlatched stable hold
        queue_probe(0, 1508, PINS_NEO, PINS_SMS, PINS_NEO);
        queue_probe(0, 1509, PINS_SMS, PINS_SMS, PINS_SMS);
        queue_probe(0, 4000, PINS_SMS, PINS_SMS, PINS_IDLE);
        // hold starting at time zero, then across the 32-bit wrap
        queue_probe(1, 0, PINS_IDLE, PINS_IDLE, PINS_IDLE);
        queue_probe(1, 0, PINS_IDLE, PINS_IDLE, PINS_JPC_B);
        queue_probe(1, 32'hFFFF_FF00, PINS_IDLE, PINS_IDLE, PINS_JPC_B);
        queue_probe(1, 32'h0000_0100, PINS_IDLE, PINS_IDLE, PINS_JPC_B);
        queue_probe(1, 32'h0000_0300, PINS_IDLE, PINS_IDLE, PINS_JPC_B);
        queue_probe(1, 32'hFFFF_FFFF, PINS_ALL_LO, PINS_ALL_LO, PINS_ALL_LO);
        queue_probe(1, 32'hFFFF_FFFF, PINS_UP, PINS_UP, PINS_UP);
        // ports out of range
        queue_probe(2, 32'hFFFF_FFFF, PINS_ALL_LO, PINS_ALL_LO, PINS_ALL_LO);
        queue_probe(8'hFF, 0, PINS_NEO, PINS_NEO, PINS_NEO);
        wait_drained();

        plan[0] = 16'd0;
        plan[1] = 16'hFFFF;
        plan[2] = 16'd1;
        plan[3] = 16'd37;
        plan[4] = $urandom_range(2, 3000);
        plan[5] = STABLE_TIME_RESET;
        for (ph = 0; ph < 6; ph++) begin
            // stable time write while the block is empty
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_stable_time_ms <= plan[ph];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            // phase 2 backs up the block behind a long receiver hold
            tx_calm = (ph == 2 || ph == 3);
            rx_calm = (ph == 3);
            if (ph == 2) rx_hold_req = 1'b1;

            while (probe_q.size() < 200) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any port, time and pins
                    p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, PORT_COUNT - 1);
                    queue_probe(p, $urandom, $urandom_range(0, 511),
                                $urandom_range(0, 511), $urandom_range(0, 511));
                end else begin
                    // press-hold-release on one port with random timing
                    p = $urandom_range(0, PORT_COUNT - 1);
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        clock_ms[p] = '0;
                    else if (r == 1)
                        clock_ms[p] = 32'hFFFF_FFFF - $urandom_range(0, 2 * stable_ms + 4);
                    repeat ($urandom_range(0, 2)) begin
                        lv = idle_pins();
                        queue_probe(p, next_probe_time(p), lv, idle_pins(), lv);
                    end
                    pat = pad_pins();
                    queue_probe(p, next_probe_time(p), pat,
                                ($urandom_range(0, 4) == 0) ? pad_pins() : pat, pat);
                    repeat ($urandom_range(0, 6))
                        queue_probe(p, next_probe_time(p), pat, pat,
                                    ($urandom_range(0, 9) == 0) ? pad_pins() : pat);
                    r = $urandom_range(0, 9);
                    lv = (r < 5) ? idle_pins() : (r < 8) ? none_pins() : pad_pins();
                    queue_probe(p, next_probe_time(p), lv, lv, lv);
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ppd_pkg.sv
design/ppd_step.sv
design/passive_pad_type_detector_top.sv
test/tb_passive_pad_type_detector_top.sv
